[rtl/core/bti_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_pkg
// Shared types and fixed field widths of the bilinear table interpolator.
// ----------------------------------------------------------------------------
package bti_pkg;

  localparam int unsigned ROW_IDX_W = 8;
  localparam int unsigned COL_IDX_W = 10;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned MOM_W     = 16;
  localparam int unsigned ENERGY_W  = 18;
  localparam int unsigned STATUS_W  = 2;

  // grid select
  localparam logic SPECIES_NEUTRON = 1'b0;
  localparam logic SPECIES_PROTON  = 1'b1;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 2'd0,
    ST_ENERGY_RANGE  = 2'd1,
    ST_MOMENTUM_HIGH = 2'd2
  } status_t;

  // classification of one queued command
  typedef struct packed {
    op_t     op;
    status_t status;
  } cmd_ctl_t;

endpackage

[rtl/core/bti_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_front
// Accepts items, classifies them, splits query coordinates into cell and
// fraction and forms the linear grid address of the first sample.
// ----------------------------------------------------------------------------
module bti_front #(
  parameter int unsigned R    = 200,
  parameter int unsigned C    = 1000,
  parameter int unsigned F    = 8,
  parameter int unsigned AW   = 19,
  parameter int unsigned FE_W = 9,
  parameter int unsigned FM_W = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_op,
  input  logic                                  in_species,
  input  logic [bti_pkg::ROW_IDX_W-1:0]         in_row_index,
  input  logic [bti_pkg::COL_IDX_W-1:0]         in_col_index,
  input  logic signed [bti_pkg::VALUE_W-1:0]    in_entry_value,
  input  logic [bti_pkg::MOM_W-1:0]             in_momentum,
  input  logic [bti_pkg::ENERGY_W-1:0]          in_energy,
  output logic                                  q_valid,
  input  logic                                  q_ready,
  output bti_pkg::cmd_ctl_t                     q_ctl,
  output logic [AW-1:0]                         q_addr,
  output logic signed [bti_pkg::VALUE_W-1:0]    q_wdata,
  output logic [FE_W-1:0]                       q_fe,
  output logic signed [FM_W-1:0]                q_fm
);

  localparam int unsigned STEP  = 1 << F;
  localparam int unsigned HALF  = STEP / 2;
  localparam int unsigned E_MAX = C * STEP - HALF;
  localparam int unsigned M_MAX = R * STEP - HALF;
  localparam int unsigned RW    = $clog2(R);
  localparam int unsigned CW    = $clog2(C);
  localparam int unsigned RLW   = $clog2(2 * R);

  logic              e_bad;
  logic              m_hi_bad;
  logic              m_neg;
  logic [31:0]       e_off;
  logic [31:0]       m_off;
  logic [31:0]       col_full;
  logic [31:0]       row_full;
  logic              col_clamp;
  logic              row_clamp;
  logic [CW-1:0]     col_d;
  logic [RW-1:0]     row_d;
  logic [FE_W-1:0]   fe_d;
  logic signed [FM_W-1:0] fm_d;
  bti_pkg::cmd_ctl_t ctl_d;
  logic              is_query;
  logic              wr_ok;
  logic              fire;
  logic              keep;

  logic              a_valid_r;
  logic              a_valid_nxt;
  bti_pkg::cmd_ctl_t a_ctl_r;
  logic              a_species_r;
  logic [RW-1:0]     a_row_r;
  logic [CW-1:0]     a_col_r;
  logic [FE_W-1:0]   a_fe_r;
  logic signed [FM_W-1:0] a_fm_r;
  logic signed [bti_pkg::VALUE_W-1:0] a_wdata_r;

  logic [RLW-1:0]    row_lin;
  logic [AW-1:0]     row_base;

  assign is_query = (bti_pkg::op_t'(in_op) == bti_pkg::OP_QUERY);
  assign wr_ok    = (32'(in_row_index) < 32'(R)) && (32'(in_col_index) < 32'(C));

  // energy axis
  assign e_bad     = (32'(in_energy) < 32'(HALF)) || (32'(in_energy) > 32'(E_MAX));
  assign e_off     = 32'(in_energy) - 32'(HALF);
  assign col_full  = e_off >> F;
  assign col_clamp = col_full > 32'(C - 2);

  // momentum axis, below the first centre extrapolates from rows 0 and 1
  assign m_hi_bad  = 32'(in_momentum) > 32'(M_MAX);
  assign m_neg     = 32'(in_momentum) < 32'(HALF);
  assign m_off     = 32'(in_momentum) - 32'(HALF);
  assign row_full  = m_off >> F;
  assign row_clamp = row_full > 32'(R - 2);

  always_comb begin
    ctl_d.op     = bti_pkg::op_t'(in_op);
    ctl_d.status = bti_pkg::ST_OK;
    col_d        = col_clamp ? CW'(C - 2) : col_full[CW-1:0];
    fe_d         = col_clamp ? FE_W'(STEP) : FE_W'(e_off[F-1:0]);
    if (m_neg) begin
      row_d = '0;
      fm_d  = FM_W'(m_off);
    end else begin
      row_d = row_clamp ? RW'(R - 2) : row_full[RW-1:0];
      fm_d  = row_clamp ? FM_W'(STEP) : FM_W'(m_off[F-1:0]);
    end
    if (!is_query) begin
      row_d = RW'(in_row_index);
      col_d = CW'(in_col_index);
    end else begin
      priority if (e_bad) begin
        ctl_d.status = bti_pkg::ST_ENERGY_RANGE;
      end else if (m_hi_bad) begin
        ctl_d.status = bti_pkg::ST_MOMENTUM_HIGH;
      end else begin
        ctl_d.status = bti_pkg::ST_OK;
      end
    end
  end

  assign in_ready = !a_valid_r || q_ready;
  assign fire     = in_valid && in_ready;
  // writes outside the grid are dropped here
  assign keep     = is_query || wr_ok;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (fire) begin
      a_valid_nxt = keep;
    end else if (q_ready) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      a_ctl_r     <= ctl_d;
      a_species_r <= in_species;
      a_row_r     <= row_d;
      a_col_r     <= col_d;
      a_fe_r      <= fe_d;
      a_fm_r      <= fm_d;
      a_wdata_r   <= in_entry_value;
    end
  end

  // linear address of the lower-left sample
  assign row_lin  = (a_species_r == bti_pkg::SPECIES_PROTON) ?
                    RLW'(R) + RLW'(a_row_r) : RLW'(a_row_r);
  assign row_base = AW'(row_lin) * AW'(C);

  assign q_valid = a_valid_r;
  assign q_ctl   = a_ctl_r;
  assign q_addr  = row_base + AW'(a_col_r);
  assign q_wdata = a_wdata_r;
  assign q_fe    = a_fe_r;
  assign q_fm    = a_fm_r;

endmodule

[rtl/core/bti_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module bti_fifo #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r;
  logic [PW-1:0]    rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             push;
  logic             pop;

  assign push_ready = count_r < CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count missed a push");

  a_count_dec: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count missed a pop");

endmodule

[rtl/core/bti_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_back
// Holds the sample grids, performs writes, reads the four corner samples of
// a query and runs the two-level interpolation pipeline.
// ----------------------------------------------------------------------------
module bti_back #(
  parameter int unsigned R    = 200,
  parameter int unsigned C    = 1000,
  parameter int unsigned F    = 8,
  parameter int unsigned AW   = 19,
  parameter int unsigned FE_W = 9,
  parameter int unsigned FM_W = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  output logic                                  q_ready,
  input  bti_pkg::cmd_ctl_t                     q_ctl,
  input  logic [AW-1:0]                         q_addr,
  input  logic signed [bti_pkg::VALUE_W-1:0]    q_wdata,
  input  logic [FE_W-1:0]                       q_fe,
  input  logic signed [FM_W-1:0]                q_fm,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [bti_pkg::VALUE_W-1:0]    out_value,
  output logic [bti_pkg::STATUS_W-1:0]          out_status
);

  localparam int unsigned VW        = bti_pkg::VALUE_W;
  localparam int unsigned STEP      = 1 << F;
  localparam int unsigned HALF      = STEP / 2;
  localparam int unsigned MEM_DEPTH = 2 * R * C;
  localparam int unsigned PW        = VW + FE_W + 1;   // first-level product
  localparam int unsigned SW        = PW + 1;
  localparam int unsigned QW        = VW + FM_W + 1;   // second-level product
  localparam int unsigned TW        = QW + 1;
  localparam int unsigned RSW       = TW - F;

  typedef enum logic [3:0] {
    STEP_LO0 = 4'b0001,
    STEP_HI0 = 4'b0010,
    STEP_LO1 = 4'b0100,
    STEP_HI1 = 4'b1000
  } step_t;

  logic adv;

  // command being carried out
  logic              cur_valid_r;
  logic              cur_valid_nxt;
  bti_pkg::cmd_ctl_t cur_ctl_r;
  logic [AW-1:0]     cur_addr_r;
  logic signed [VW-1:0] cur_wdata_r;
  logic [FE_W-1:0]   cur_fe_r;
  logic signed [FM_W-1:0] cur_fm_r;
  step_t             step_r;
  step_t             step_nxt;
  step_t             step_inc;
  logic              is_read;
  logic              is_err;
  logic              cur_last;
  logic              load;

  // grid memory
  logic signed [VW-1:0] grid_mem [MEM_DEPTH];
  logic [AW-1:0]     mem_addr;
  logic              mem_we;
  logic              mem_re;
  logic signed [VW-1:0] rdata_r;

  // read stage
  logic              r_valid_r;
  logic              r_last_r;
  step_t             r_step_r;
  bti_pkg::status_t  r_status_r;
  logic [FE_W-1:0]   r_fe_r;
  logic signed [FM_W-1:0] r_fm_r;
  logic signed [VW-1:0] s_lo0_r;
  logic signed [VW-1:0] s_hi0_r;
  logic signed [VW-1:0] s_lo1_r;

  // energy blend products
  logic signed [FE_W:0] fe_s;
  logic signed [FE_W:0] we_lo;
  logic              m1_valid_r;
  bti_pkg::status_t  m1_status_r;
  logic signed [FM_W-1:0] m1_fm_r;
  logic signed [PW-1:0] m1_p0lo_r;
  logic signed [PW-1:0] m1_p0hi_r;
  logic signed [PW-1:0] m1_p1lo_r;
  logic signed [PW-1:0] m1_p1hi_r;

  // row values
  logic signed [SW-1:0] sum0;
  logic signed [SW-1:0] sum1;
  logic              m2_valid_r;
  bti_pkg::status_t  m2_status_r;
  logic signed [FM_W-1:0] m2_fm_r;
  logic signed [VW-1:0] m2_a0_r;
  logic signed [VW-1:0] m2_a1_r;

  // momentum blend products
  logic signed [FM_W:0] wm_lo;
  logic signed [FM_W:0] wm_hi;
  logic              m3_valid_r;
  bti_pkg::status_t  m3_status_r;
  logic signed [QW-1:0] m3_q0_r;
  logic signed [QW-1:0] m3_q1_r;

  // final rounding and saturation
  logic signed [TW-1:0]  total;
  logic signed [RSW-1:0] rnd;
  logic                  fits;
  logic signed [VW-1:0]  sat;
  logic                  out_valid_r;
  logic signed [VW-1:0]  out_value_r;
  bti_pkg::status_t      out_status_r;

  assign adv = !out_valid_r || out_ready;

  assign is_read  = cur_valid_r && (cur_ctl_r.op == bti_pkg::OP_QUERY) &&
                    (cur_ctl_r.status == bti_pkg::ST_OK);
  assign is_err   = cur_valid_r && (cur_ctl_r.op == bti_pkg::OP_QUERY) &&
                    (cur_ctl_r.status != bti_pkg::ST_OK);
  assign cur_last = cur_valid_r && (!is_read || step_r == STEP_HI1);
  assign q_ready  = adv && (!cur_valid_r || cur_last);
  assign load     = q_ready && q_valid;

  always_comb begin
    unique case (step_r)
      STEP_LO0: begin
        step_inc = STEP_HI0;
        mem_addr = cur_addr_r;
      end
      STEP_HI0: begin
        step_inc = STEP_LO1;
        mem_addr = cur_addr_r + 1'b1;
      end
      STEP_LO1: begin
        step_inc = STEP_HI1;
        mem_addr = cur_addr_r + AW'(C);
      end
      STEP_HI1: begin
        step_inc = STEP_LO0;
        mem_addr = cur_addr_r + AW'(C + 1);
      end
      default: begin
        step_inc = STEP_LO0;
        mem_addr = cur_addr_r;
      end
    endcase
  end

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    step_nxt      = step_r;
    if (adv) begin
      if (!cur_valid_r || cur_last) begin
        cur_valid_nxt = q_valid;
        step_nxt      = STEP_LO0;
      end else begin
        step_nxt = step_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= STEP_LO0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_ctl_r   <= q_ctl;
      cur_addr_r  <= q_addr;
      cur_wdata_r <= q_wdata;
      cur_fe_r    <= q_fe;
      cur_fm_r    <= q_fm;
    end
  end

  assign mem_we = adv && cur_valid_r && (cur_ctl_r.op == bti_pkg::OP_WRITE);
  assign mem_re = adv && is_read;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_addr] <= cur_wdata_r;
    end
    if (mem_re) begin
      rdata_r <= grid_mem[mem_addr];
    end
  end

  // read stage travels beside the registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_valid_r <= 1'b0;
    end else if (adv) begin
      r_valid_r <= mem_re || is_err;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_last_r   <= is_err || (step_r == STEP_HI1);
      r_step_r   <= step_r;
      r_status_r <= cur_ctl_r.status;
      r_fe_r     <= cur_fe_r;
      r_fm_r     <= cur_fm_r;
      if (r_valid_r && r_step_r == STEP_LO0) begin
        s_lo0_r <= rdata_r;
      end
      if (r_valid_r && r_step_r == STEP_HI0) begin
        s_hi0_r <= rdata_r;
      end
      if (r_valid_r && r_step_r == STEP_LO1) begin
        s_lo1_r <= rdata_r;
      end
    end
  end

  assign fe_s  = (FE_W + 1)'({1'b0, r_fe_r});
  assign we_lo = (FE_W + 1)'(STEP) - fe_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
      m2_valid_r <= 1'b0;
      m3_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      m1_valid_r  <= r_valid_r && r_last_r;
      m2_valid_r  <= m1_valid_r;
      m3_valid_r  <= m2_valid_r;
      out_valid_r <= m3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_status_r <= r_status_r;
      m1_fm_r     <= r_fm_r;
      m1_p0lo_r   <= PW'(s_lo0_r) * PW'(we_lo);
      m1_p0hi_r   <= PW'(s_hi0_r) * PW'(fe_s);
      m1_p1lo_r   <= PW'(s_lo1_r) * PW'(we_lo);
      m1_p1hi_r   <= PW'(rdata_r) * PW'(fe_s);
    end
  end

  // round half up: floor((x + half) / step)
  assign sum0 = SW'(m1_p0lo_r) + SW'(m1_p0hi_r) + SW'(HALF);
  assign sum1 = SW'(m1_p1lo_r) + SW'(m1_p1hi_r) + SW'(HALF);

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_status_r <= m1_status_r;
      m2_fm_r     <= m1_fm_r;
      m2_a0_r     <= sum0[F+VW-1:F];
      m2_a1_r     <= sum1[F+VW-1:F];
    end
  end

  // negative fraction extrapolates below row 0
  assign wm_hi = (FM_W + 1)'(m2_fm_r);
  assign wm_lo = (FM_W + 1)'(STEP) - wm_hi;

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_status_r <= m2_status_r;
      m3_q0_r     <= QW'(m2_a0_r) * QW'(wm_lo);
      m3_q1_r     <= QW'(m2_a1_r) * QW'(wm_hi);
    end
  end

  assign total = TW'(m3_q0_r) + TW'(m3_q1_r) + TW'(HALF);
  assign rnd   = total[TW-1:F];
  assign fits  = (rnd[RSW-1:VW-1] == '0) || (rnd[RSW-1:VW-1] == '1);

  always_comb begin
    if (fits) begin
      sat = rnd[VW-1:0];
    end else if (rnd[RSW-1]) begin
      sat = {1'b1, {(VW - 1){1'b0}}};
    end else begin
      sat = {1'b0, {(VW - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r <= m3_status_r;
      out_value_r  <= (m3_status_r == bti_pkg::ST_OK) ? sat : '0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  a_fourth_read_last: assert property (@(posedge clk) disable iff (!rst_n)
    r_valid_r && r_last_r && (r_status_r == bti_pkg::ST_OK) |-> r_step_r == STEP_HI1)
    else $error("query finished before its fourth corner read");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(cur_addr_r) && $stable(step_r) && $stable(r_valid_r))
    else $error("back end moved while the result was stalled");

  a_write_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (cur_ctl_r.status == bti_pkg::ST_OK) && !mem_re)
    else $error("grid write with an error status or a read alongside");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != bti_pkg::ST_OK) |-> out_value_r == '0)
    else $error("error result carries a nonzero value");

endmodule

[rtl/core/bilinear_table_interpolator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_table_interpolator
// Two sample grids (neutron, proton) with write items and bilinear queries.
// ----------------------------------------------------------------------------
// A write needs a single grid access in the back end; a query in range reads
// its four corner samples from the single-port grid memory, one per cycle
// unless the output stalls, and takes no new command before its fourth read;
// writes go one per cycle unless stalled. Out-of-range queries do no reads.
// Grid contents are undefined until written; there is no clearing pass.
// Out-of-range writes are dropped and no result is returned for any write.
module bilinear_table_interpolator #(
  parameter int unsigned MOMENTUM_ROWS = 200,
  parameter int unsigned ENERGY_COLS   = 1000,
  parameter int unsigned FRAC_BITS     = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_op,
  input  logic                               in_species,
  input  logic [bti_pkg::ROW_IDX_W-1:0]      in_row_index,
  input  logic [bti_pkg::COL_IDX_W-1:0]      in_col_index,
  input  logic signed [bti_pkg::VALUE_W-1:0] in_entry_value,
  input  logic [bti_pkg::MOM_W-1:0]          in_momentum,
  input  logic [bti_pkg::ENERGY_W-1:0]       in_energy,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [bti_pkg::VALUE_W-1:0] out_value,
  output logic [bti_pkg::STATUS_W-1:0]       out_status
);

  localparam int unsigned AW    = $clog2(2 * MOMENTUM_ROWS * ENERGY_COLS);
  localparam int unsigned FE_W  = FRAC_BITS + 1;
  localparam int unsigned FM_W  = FRAC_BITS + 2;
  localparam int unsigned CTL_W = $bits(bti_pkg::cmd_ctl_t);
  localparam int unsigned QD_W  = CTL_W + AW + bti_pkg::VALUE_W + FE_W + FM_W;
  localparam int unsigned Q_DEPTH = 4;

  logic                               f_valid;
  logic                               f_ready;
  bti_pkg::cmd_ctl_t                  f_ctl;
  logic [AW-1:0]                      f_addr;
  logic signed [bti_pkg::VALUE_W-1:0] f_wdata;
  logic [FE_W-1:0]                    f_fe;
  logic signed [FM_W-1:0]             f_fm;

  logic                               b_valid;
  logic                               b_ready;
  bti_pkg::cmd_ctl_t                  b_ctl;
  logic [AW-1:0]                      b_addr;
  logic signed [bti_pkg::VALUE_W-1:0] b_wdata;
  logic [FE_W-1:0]                    b_fe;
  logic signed [FM_W-1:0]             b_fm;

  logic [QD_W-1:0]                    push_data;
  logic [QD_W-1:0]                    pop_data;

  bti_front #(
    .R    (MOMENTUM_ROWS),
    .C    (ENERGY_COLS),
    .F    (FRAC_BITS),
    .AW   (AW),
    .FE_W (FE_W),
    .FM_W (FM_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_species     (in_species),
    .in_row_index   (in_row_index),
    .in_col_index   (in_col_index),
    .in_entry_value (in_entry_value),
    .in_momentum    (in_momentum),
    .in_energy      (in_energy),
    .q_valid        (f_valid),
    .q_ready        (f_ready),
    .q_ctl          (f_ctl),
    .q_addr         (f_addr),
    .q_wdata        (f_wdata),
    .q_fe           (f_fe),
    .q_fm           (f_fm)
  );

  assign push_data = {f_ctl, f_addr, f_wdata, f_fe, f_fm};

  bti_fifo #(
    .WIDTH (QD_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (push_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (pop_data)
  );

  assign {b_ctl, b_addr, b_wdata, b_fe, b_fm} = pop_data;

  bti_back #(
    .R    (MOMENTUM_ROWS),
    .C    (ENERGY_COLS),
    .F    (FRAC_BITS),
    .AW   (AW),
    .FE_W (FE_W),
    .FM_W (FM_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (b_valid),
    .q_ready    (b_ready),
    .q_ctl      (b_ctl),
    .q_addr     (b_addr),
    .q_wdata    (b_wdata),
    .q_fe       (b_fe),
    .q_fm       (b_fm),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule
